FILE: hdl/ftjg_pkg.sv
// Shared types and constants of the feeder trigger and jam guard.
package ftjg_pkg;

    // Remote switch positions.
    typedef enum logic [1:0] {
        SW_UNKNOWN = 2'd0,
        SW_UP      = 2'd1,
        SW_MIDDLE  = 2'd2,
        SW_DOWN    = 2'd3
    } switch_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WORKING_SPEED       = 3'd0,
        CFG_SAFE_SPEED          = 3'd1,
        CFG_EJECT_SPEED         = 3'd2,
        CFG_DEEP_EJECT_SPEED    = 3'd3,
        CFG_EJECT_TICKS         = 3'd4,
        CFG_DEEP_EJECT_TICKS    = 3'd5,
        CFG_SINGLE_WINDOW_TICKS = 3'd6
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SPEED_W     = 16;
    localparam int TICKS_W     = 16;
    localparam int HEAT_W      = 10;
    localparam int RUN_W       = 11;
    localparam int TEMP_W      = 9;
    localparam int JAM_W       = 2;

    localparam logic signed [RUN_W-1:0] RUN_LIMIT   = 11'sd500;
    localparam logic [TEMP_W-1:0]       TEMP_WINDOW = 9'd500;
    localparam logic [JAM_W-1:0]        JAM_MAX     = 2'd3;
    localparam logic [JAM_W-1:0]        DEEP_FROM   = 2'd2;

    typedef struct packed {
        logic signed [SPEED_W-1:0] working_speed;
        logic signed [SPEED_W-1:0] safe_speed;
        logic signed [SPEED_W-1:0] eject_speed;
        logic signed [SPEED_W-1:0] deep_eject_speed;
        logic [TICKS_W-1:0]        eject_ticks;
        logic [TICKS_W-1:0]        deep_eject_ticks;
        logic [TICKS_W-1:0]        single_window_ticks;
    } cfg_t;

    typedef struct packed {
        switch_t                   left_switch;
        switch_t                   right_switch;
        logic                      mouse_left;
        logic                      key_single;
        logic                      wheels_ready;
        logic                      shot_fired;
        logic [HEAT_W-1:0]         heat_allowance;
        logic                      auto_fire;
        logic signed [SPEED_W-1:0] measured_speed;
    } item_t;

    typedef struct packed {
        logic                      single_mode;
        logic                      command_valid;
        logic signed [SPEED_W-1:0] command_speed;
    } result_t;

endpackage

FILE: hdl/ftjg_tick_if.sv
// Input channel carrying one control tick.
interface ftjg_tick_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             left_switch;
    logic [1:0]                             right_switch;
    logic                                   mouse_left;
    logic                                   key_single;
    logic                                   wheels_ready;
    logic                                   shot_fired;
    logic [ftjg_pkg::HEAT_W-1:0]            heat_allowance;
    logic                                   auto_fire;
    logic signed [ftjg_pkg::SPEED_W-1:0]    measured_speed;

    modport source (
        output valid, left_switch, right_switch, mouse_left, key_single,
               wheels_ready, shot_fired, heat_allowance, auto_fire, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, left_switch, right_switch, mouse_left, key_single,
               wheels_ready, shot_fired, heat_allowance, auto_fire, measured_speed,
        output ready
    );
endinterface

FILE: hdl/ftjg_result_if.sv
// Output channel carrying one feeder command.
interface ftjg_result_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   single_mode;
    logic                                   command_valid;
    logic signed [ftjg_pkg::SPEED_W-1:0]    command_speed;

    modport source (
        output valid, single_mode, command_valid, command_speed,
        input  ready
    );
    modport sink (
        input  valid, single_mode, command_valid, command_speed,
        output ready
    );
endinterface

FILE: hdl/ftjg_core.sv
// Tick state of the trigger logic and jam guard, with its one-pass update.
module ftjg_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  ftjg_pkg::item_t     item,
    input  ftjg_pkg::cfg_t      cfg,
    output ftjg_pkg::result_t   result
);

    logic [1:0]                                 prev_left_reg, prev_left_next;
    logic                                       prev_mouse_reg, prev_mouse_next;
    logic [ftjg_pkg::TICKS_W-1:0]               single_window_reg, single_window_next;
    logic [ftjg_pkg::TEMP_W-1:0]                temp_window_reg, temp_window_next;
    logic signed [ftjg_pkg::RUN_W-1:0]          run_status_reg, run_status_next;
    logic [ftjg_pkg::JAM_W-1:0]                 jam_count_reg, jam_count_next;
    logic [ftjg_pkg::TICKS_W-1:0]               cool_down_reg, cool_down_next;
    logic signed [ftjg_pkg::SPEED_W-1:0]        speed_reg, speed_next;
    logic                                       speed_valid_reg, speed_valid_next;
    logic                                       single_mode_reg, single_mode_next;
    logic                                       bad_switch;

    assign bad_switch = (item.left_switch == ftjg_pkg::SW_UNKNOWN)
                     || (item.right_switch == ftjg_pkg::SW_UNKNOWN)
                     || ((item.left_switch == ftjg_pkg::SW_DOWN)
                         && (item.right_switch == ftjg_pkg::SW_DOWN));

    always_comb
    begin
        logic [ftjg_pkg::HEAT_W-1:0]        allowance;
        logic                               trig;
        logic signed [ftjg_pkg::SPEED_W:0]  twice_measured;
        logic signed [ftjg_pkg::SPEED_W:0]  speed_ext;
        logic signed [ftjg_pkg::SPEED_W-1:0] target;
        logic                               jam;

        prev_left_next     = item.left_switch;
        prev_mouse_next    = item.mouse_left;
        single_window_next = single_window_reg;
        temp_window_next   = temp_window_reg;
        run_status_next    = run_status_reg;
        jam_count_next     = jam_count_reg;
        cool_down_next     = cool_down_reg;
        speed_next         = speed_reg;
        speed_valid_next   = speed_valid_reg;
        single_mode_next   = single_mode_reg;
        allowance          = '0;
        trig               = 1'b0;
        jam                = 1'b0;
        twice_measured     = $signed({item.measured_speed, 1'b0});
        speed_ext          = '0;
        target             = '0;

        if (bad_switch)
        begin
            single_mode_next = 1'b0;
            speed_valid_next = 1'b0;
            speed_next       = '0;
        end
        else
        begin
            if (item.right_switch != ftjg_pkg::SW_DOWN)
            begin
                single_mode_next = item.key_single;
                if (single_window_next != '0)
                    single_window_next = single_window_next - 1'b1;
                if (temp_window_next != '0)
                    temp_window_next = temp_window_next - 1'b1;
                if (!prev_mouse_reg && item.mouse_left)
                begin
                    single_window_next = cfg.single_window_ticks;
                end
                else if ((prev_left_reg != ftjg_pkg::SW_DOWN)
                         && (item.left_switch == ftjg_pkg::SW_DOWN))
                begin
                    single_window_next = cfg.single_window_ticks;
                    temp_window_next   = ftjg_pkg::TEMP_WINDOW;
                end
                if (temp_window_next != '0)
                    single_mode_next = 1'b1;
                if (item.shot_fired)
                    single_window_next = '0;
                if (item.wheels_ready)
                begin
                    if (!single_mode_next)
                    begin
                        trig = item.mouse_left
                            || (item.left_switch == ftjg_pkg::SW_DOWN)
                            || ((item.right_switch == ftjg_pkg::SW_UP) && item.auto_fire);
                        allowance = trig ? item.heat_allowance : '0;
                    end
                    else
                    begin
                        allowance = ((single_window_next != '0)
                                     && (item.heat_allowance != '0))
                                    ? ftjg_pkg::HEAT_W'(1) : '0;
                    end
                end
            end

            if (allowance == '0)
            begin
                run_status_next  = '0;
                speed_next       = '0;
                speed_valid_next = 1'b1;
            end
            else
            begin
                // Jam detection runs only while a positive speed is commanded.
                speed_ext = $signed({speed_reg[ftjg_pkg::SPEED_W-1], speed_reg});
                if (speed_valid_reg && !speed_reg[ftjg_pkg::SPEED_W-1] && (speed_reg != '0))
                begin
                    if (twice_measured > speed_ext)
                    begin
                        if (run_status_reg < 0)
                            run_status_next = '0;
                        else if (run_status_reg < ftjg_pkg::RUN_LIMIT)
                            run_status_next = run_status_reg + ftjg_pkg::RUN_W'(1);
                        else
                            jam_count_next = '0;
                    end
                    else
                    begin
                        if (run_status_reg == ftjg_pkg::RUN_LIMIT)
                            jam = 1'b1;
                        else if (run_status_reg > 0)
                            run_status_next = '0;
                        else if (run_status_reg > -ftjg_pkg::RUN_LIMIT)
                            run_status_next = run_status_reg - ftjg_pkg::RUN_W'(1);
                        else
                            jam = 1'b1;
                    end
                end

                if (jam)
                begin
                    run_status_next = '0;
                    if (jam_count_reg != ftjg_pkg::JAM_MAX)
                        jam_count_next = jam_count_reg + 1'b1;
                    if (jam_count_next <= ftjg_pkg::DEEP_FROM)
                    begin
                        speed_next     = cfg.eject_speed;
                        cool_down_next = cfg.eject_ticks;
                    end
                    else
                    begin
                        speed_next     = cfg.deep_eject_speed;
                        cool_down_next = cfg.deep_eject_ticks;
                    end
                    speed_valid_next = 1'b1;
                end

                // A fresh eject starts counting its cool-down on the same tick.
                if (cool_down_next != '0)
                begin
                    cool_down_next = cool_down_next - 1'b1;
                end
                else
                begin
                    target = (allowance > ftjg_pkg::HEAT_W'(1)) ? cfg.working_speed
                                                                : cfg.safe_speed;
                    if (speed_valid_next && (target > speed_next) && (run_status_next > 0))
                        run_status_next = '0;
                    speed_next       = target;
                    speed_valid_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.single_mode   = single_mode_next;
        result.command_valid = speed_valid_next;
        result.command_speed = speed_valid_next ? speed_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg     <= ftjg_pkg::SW_UNKNOWN;
            prev_mouse_reg    <= 1'b0;
            single_window_reg <= '0;
            temp_window_reg   <= '0;
            run_status_reg    <= '0;
            jam_count_reg     <= '0;
            cool_down_reg     <= '0;
            speed_reg         <= '0;
            speed_valid_reg   <= 1'b0;
            single_mode_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            prev_left_reg     <= prev_left_next;
            prev_mouse_reg    <= prev_mouse_next;
            single_window_reg <= single_window_next;
            temp_window_reg   <= temp_window_next;
            run_status_reg    <= run_status_next;
            jam_count_reg     <= jam_count_next;
            cool_down_reg     <= cool_down_next;
            speed_reg         <= speed_next;
            speed_valid_reg   <= speed_valid_next;
            single_mode_reg   <= single_mode_next;
        end
    end

    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        (run_status_reg <= ftjg_pkg::RUN_LIMIT) && (run_status_reg >= -ftjg_pkg::RUN_LIMIT))
        else $error("run status left its range");

    a_temp_window: assert property (@(posedge clk) disable iff (!rst_n)
        temp_window_reg <= ftjg_pkg::TEMP_WINDOW)
        else $error("temporary single-shot window above its start value");

    a_jam_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> (jam_count_reg == $past(jam_count_reg))
                 || (jam_count_reg == '0)
                 || (jam_count_reg == $past(jam_count_reg) + 1'b1))
        else $error("jam count moved by more than one step");

    a_bad_switch: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && bad_switch |=> !speed_valid_reg && !single_mode_reg)
        else $error("bad switch state left a valid command");

endmodule

FILE: hdl/feeder_trigger_and_jam_guard.sv
// Top level of the feeder trigger and jam guard: configuration, handshake, result register.
//
// One control tick is taken per clock cycle while tick.ready is high: the whole tick update
// runs in one pass through the state registers of ftjg_core, and the command lands in
// the result register at the clock edge of the transfer, so it is offered in the cycle
// after the tick is taken. A new tick is taken whenever the result register is empty or
// its command is being taken in the same cycle, so the sustained rate is one tick per
// cycle while result.ready holds. Configuration registers reset to zero and are written
// through cfg_we, cfg_index and cfg_data; an index beyond the last register is ignored.
module feeder_trigger_and_jam_guard (
    input  logic                                clk,
    input  logic                                rst_n,
    ftjg_tick_if.sink                           tick,
    ftjg_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [ftjg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ftjg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ftjg_pkg::cfg_t     cfg_reg;
    ftjg_pkg::item_t    item;
    ftjg_pkg::result_t  step_result;
    ftjg_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic               step_en;

    assign tick.ready = !out_valid_reg || result.ready;
    assign step_en    = tick.valid && tick.ready;

    always_comb
    begin
        item.left_switch    = ftjg_pkg::switch_t'(tick.left_switch);
        item.right_switch   = ftjg_pkg::switch_t'(tick.right_switch);
        item.mouse_left     = tick.mouse_left;
        item.key_single     = tick.key_single;
        item.wheels_ready   = tick.wheels_ready;
        item.shot_fired     = tick.shot_fired;
        item.heat_allowance = tick.heat_allowance;
        item.auto_fire      = tick.auto_fire;
        item.measured_speed = tick.measured_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (ftjg_pkg::cfg_index_t'(cfg_index))
                ftjg_pkg::CFG_WORKING_SPEED:       cfg_reg.working_speed       <= cfg_data;
                ftjg_pkg::CFG_SAFE_SPEED:          cfg_reg.safe_speed          <= cfg_data;
                ftjg_pkg::CFG_EJECT_SPEED:         cfg_reg.eject_speed         <= cfg_data;
                ftjg_pkg::CFG_DEEP_EJECT_SPEED:    cfg_reg.deep_eject_speed    <= cfg_data;
                ftjg_pkg::CFG_EJECT_TICKS:         cfg_reg.eject_ticks         <= cfg_data;
                ftjg_pkg::CFG_DEEP_EJECT_TICKS:    cfg_reg.deep_eject_ticks    <= cfg_data;
                ftjg_pkg::CFG_SINGLE_WINDOW_TICKS: cfg_reg.single_window_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    ftjg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= step_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.single_mode   = out_reg.single_mode;
    assign result.command_valid = out_reg.command_valid;
    assign result.command_speed = out_reg.command_speed;

endmodule
